### sv/assert_macros.svh
// assertion helpers used by the checker file esp_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CHK_HOLDS(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("encoder tracker check failed");

// cond in one cycle implies expr in the next
`define CHK_NEXT(label, clk, rstn, cond, expr) \
    `CHK_HOLDS(label, clk, rstn, (cond) |=> (expr))

`endif

### sv/esp_pkg.sv
// constants, register codes and sequencer states of the encoder speed/position tracker
// no dependencies
package esp_pkg;

    localparam int TIME_WIDTH_DEFAULT = 32;

    localparam int ACC_W   = 56;
    localparam int RATE_W  = 20;
    localparam int FILT_W  = 32;
    localparam int RPC_W   = 24;
    localparam int CNT_W   = 5;

    localparam logic [RATE_W-1:0] RATE_NUMERATOR = 20'd1000000;
    localparam logic [11:0]       COEF_KEEP      = 12'd3498;
    localparam logic [11:0]       COEF_NEW       = 12'd298;
    localparam logic [ACC_W-1:0]  ROUND_HALF     = 56'd2048;

    localparam logic [RPC_W-1:0]  RPC_RESET      = 24'd105414;
    localparam logic [31:0]       TIMEOUT_RESET  = 32'd100000;

    localparam logic [CNT_W-1:0]  DIV_STEPS      = 5'd20;
    localparam logic [CNT_W-1:0]  KEEP_STEPS     = 5'd12;
    localparam logic [CNT_W-1:0]  NEW_STEPS      = 5'd9;
    localparam logic [CNT_W-1:0]  MUL_STEPS      = 5'd24;

    localparam logic [0:0] CFG_IDX_RPC     = 1'b0;
    localparam logic [0:0] CFG_IDX_TIMEOUT = 1'b1;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAP,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_EDGE_DONE,
        ST_STALL,
        ST_KEEP_LOAD,
        ST_KEEP_RUN,
        ST_NEW_LOAD,
        ST_NEW_RUN,
        ST_FILT_DONE,
        ST_ANGLE_LOAD,
        ST_ANGLE_RUN,
        ST_SPEED_LOAD,
        ST_SPEED_RUN,
        ST_RESULT
    } state_t;

endpackage

### sv/encoder_speed_position_tracker.sv
// encoder speed and position tracker: edge period divide, rate filter, angle/speed scaling
// depends on esp_pkg; one shared 56-bit adder does every divide and multiply step
// one item at a time: s_ready is high only in ST_IDLE, so a new item waits until the 20-step divide
// (edge) or the filter multiplies (read) and the 24-step angle and speed multiplies are through;
// a new item is taken while the previous result still waits
// reset: synchronous active-low aresetn resets state and the control and architectural registers
module encoder_speed_position_tracker #(
    parameter int TIME_WIDTH = esp_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [31:0]        cfg_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic [31:0]        s_time_us,
    input  logic               s_direction_level,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_position_count,
    output logic signed [47:0] m_angle_rad,
    output logic [39:0]        m_angular_velocity
);

    localparam int AW = esp_pkg::ACC_W;
    localparam int GW = (TIME_WIDTH > 21) ? TIME_WIDTH : 21;
    localparam int CW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

    esp_pkg::state_t state_reg, state_next;

    logic [esp_pkg::RPC_W-1:0]  rpc_reg;
    logic [31:0]                timeout_reg;

    logic [TIME_WIDTH-1:0]      edge_time_reg;
    logic [esp_pkg::RATE_W-1:0] raw_rate_reg;
    logic [esp_pkg::RATE_W-1:0] prior_rate_reg;
    logic [esp_pkg::FILT_W-1:0] filtered_reg;
    logic [31:0]                position_reg;

    logic                       op_reg;
    logic                       dir_reg;
    logic [TIME_WIDTH-1:0]      time_reg;
    logic [TIME_WIDTH-1:0]      gap_reg;

    logic [AW-1:0]              acc_reg;
    logic [AW-1:0]              mcand_reg;
    logic [esp_pkg::RPC_W-1:0]  mplier_reg;
    logic [esp_pkg::CNT_W-1:0]  cnt_reg;
    logic [esp_pkg::RATE_W-1:0] quot_reg;
    logic                       div_big_reg;
    logic [47:0]                angle_hold_reg;

    logic                       m_valid_reg;
    logic signed [31:0]         m_position_reg;
    logic signed [47:0]         m_angle_reg;
    logic [39:0]                m_speed_reg;

    // shared adder
    logic                       div_mode;
    logic [AW-1:0]              div_base;
    logic [AW-1:0]              add_a;
    logic [AW-1:0]              add_b;
    logic [AW-1:0]              add_sum;
    logic                       div_keep;

    logic                       in_xfer;
    logic                       last_step;
    logic                       result_load;

    logic [GW-1:0]              gap_ext;
    logic [20:0]                divisor;
    logic                       gap_big;
    logic [20:0]                rate_sum;
    logic [esp_pkg::FILT_W-1:0] filt_sat;

    assign cfg_ready          = 1'b1;
    assign m_valid            = m_valid_reg;
    assign m_position_count   = m_position_reg;
    assign m_angle_rad        = m_angle_reg;
    assign m_angular_velocity = m_speed_reg;

    // restoring divide: shift in the next numerator bit, subtract divisor
    assign div_base = {acc_reg[AW-2:0], mplier_reg[esp_pkg::RPC_W-1]};
    assign add_a    = div_mode ? div_base : acc_reg;
    assign add_b    = div_mode ? (~mcand_reg + AW'(1))
                               : (mplier_reg[0] ? mcand_reg : '0);
    assign add_sum  = add_a + add_b;
    assign div_keep = !div_big_reg && !add_sum[AW-1];

    // gaps of 2^21 or more give a zero quotient
    assign gap_ext  = GW'(gap_reg);
    assign gap_big  = |(gap_ext >> 21);
    assign divisor  = (gap_reg == '0) ? 21'd1 : gap_ext[20:0];

    assign rate_sum = 21'(raw_rate_reg) + 21'(prior_rate_reg);
    assign filt_sat = (|acc_reg[AW-1:44]) ? '1 : acc_reg[43:12];

    // control decode
    always_comb begin
        s_ready     = (state_reg == esp_pkg::ST_IDLE);
        in_xfer     = s_valid && s_ready;
        div_mode    = (state_reg == esp_pkg::ST_DIV_RUN);
        last_step   = (cnt_reg == esp_pkg::CNT_W'(1));
        result_load = (state_reg == esp_pkg::ST_RESULT) && (!m_valid_reg || m_ready);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            esp_pkg::ST_IDLE: begin
                if (in_xfer) state_next = esp_pkg::ST_GAP;
            end
            esp_pkg::ST_GAP: begin
                state_next = (op_reg == esp_pkg::OP_READ) ? esp_pkg::ST_STALL
                                                          : esp_pkg::ST_DIV_LOAD;
            end
            esp_pkg::ST_DIV_LOAD:  state_next = esp_pkg::ST_DIV_RUN;
            esp_pkg::ST_DIV_RUN: begin
                if (last_step) state_next = esp_pkg::ST_EDGE_DONE;
            end
            esp_pkg::ST_EDGE_DONE: state_next = esp_pkg::ST_ANGLE_LOAD;
            esp_pkg::ST_STALL:     state_next = esp_pkg::ST_KEEP_LOAD;
            esp_pkg::ST_KEEP_LOAD: state_next = esp_pkg::ST_KEEP_RUN;
            esp_pkg::ST_KEEP_RUN: begin
                if (last_step) state_next = esp_pkg::ST_NEW_LOAD;
            end
            esp_pkg::ST_NEW_LOAD:  state_next = esp_pkg::ST_NEW_RUN;
            esp_pkg::ST_NEW_RUN: begin
                if (last_step) state_next = esp_pkg::ST_FILT_DONE;
            end
            esp_pkg::ST_FILT_DONE:  state_next = esp_pkg::ST_ANGLE_LOAD;
            esp_pkg::ST_ANGLE_LOAD: state_next = esp_pkg::ST_ANGLE_RUN;
            esp_pkg::ST_ANGLE_RUN: begin
                if (last_step) state_next = esp_pkg::ST_SPEED_LOAD;
            end
            esp_pkg::ST_SPEED_LOAD: state_next = esp_pkg::ST_SPEED_RUN;
            esp_pkg::ST_SPEED_RUN: begin
                if (last_step) state_next = esp_pkg::ST_RESULT;
            end
            esp_pkg::ST_RESULT: begin
                if (result_load) state_next = esp_pkg::ST_IDLE;
            end
            default: state_next = esp_pkg::ST_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= esp_pkg::ST_IDLE;
            m_valid_reg    <= 1'b0;
            rpc_reg        <= esp_pkg::RPC_RESET;
            timeout_reg    <= esp_pkg::TIMEOUT_RESET;
            edge_time_reg  <= '0;
            raw_rate_reg   <= '0;
            prior_rate_reg <= '0;
            filtered_reg   <= '0;
            position_reg   <= '0;
        end else begin
            state_reg <= state_next;

            if (result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    esp_pkg::CFG_IDX_RPC:     rpc_reg     <= cfg_data[esp_pkg::RPC_W-1:0];
                    esp_pkg::CFG_IDX_TIMEOUT: timeout_reg <= cfg_data;
                    default: ;
                endcase
            end

            unique case (state_reg)
                esp_pkg::ST_EDGE_DONE: begin
                    raw_rate_reg  <= quot_reg;
                    edge_time_reg <= time_reg;
                    position_reg  <= dir_reg ? position_reg + 32'd1 : position_reg - 32'd1;
                end
                esp_pkg::ST_STALL: begin
                    if (CW'(gap_reg) > CW'(timeout_reg)) raw_rate_reg <= '0;
                end
                esp_pkg::ST_FILT_DONE: begin
                    filtered_reg   <= filt_sat;
                    prior_rate_reg <= raw_rate_reg;
                end
                default: ;
            endcase
        end
    end

    // datapath around the shared adder
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            op_reg   <= s_operation;
            dir_reg  <= s_direction_level;
            time_reg <= TIME_WIDTH'(s_time_us);
        end

        unique case (state_reg)
            esp_pkg::ST_GAP: begin
                // time difference wraps with the timestamp width
                gap_reg <= time_reg - edge_time_reg;
            end
            esp_pkg::ST_DIV_LOAD: begin
                acc_reg     <= '0;
                mcand_reg   <= AW'(divisor);
                div_big_reg <= gap_big;
                mplier_reg  <= {esp_pkg::RATE_NUMERATOR, 4'b0000};
                cnt_reg     <= esp_pkg::DIV_STEPS;
            end
            esp_pkg::ST_DIV_RUN: begin
                acc_reg    <= div_keep ? add_sum : div_base;
                quot_reg   <= {quot_reg[esp_pkg::RATE_W-2:0], div_keep};
                mplier_reg <= mplier_reg << 1;
                cnt_reg    <= cnt_reg - esp_pkg::CNT_W'(1);
            end
            esp_pkg::ST_KEEP_LOAD: begin
                // rounding constant preloaded so the final shift rounds half up
                acc_reg    <= esp_pkg::ROUND_HALF;
                mcand_reg  <= AW'(filtered_reg);
                mplier_reg <= esp_pkg::RPC_W'(esp_pkg::COEF_KEEP);
                cnt_reg    <= esp_pkg::KEEP_STEPS;
            end
            esp_pkg::ST_NEW_LOAD: begin
                mcand_reg  <= AW'(rate_sum) << 12;
                mplier_reg <= esp_pkg::RPC_W'(esp_pkg::COEF_NEW);
                cnt_reg    <= esp_pkg::NEW_STEPS;
            end
            esp_pkg::ST_ANGLE_LOAD: begin
                // signed position times unsigned scale, exact modulo 2^56
                acc_reg    <= '0;
                mcand_reg  <= {{(AW-32){position_reg[31]}}, position_reg};
                mplier_reg <= rpc_reg;
                cnt_reg    <= esp_pkg::MUL_STEPS;
            end
            esp_pkg::ST_SPEED_LOAD: begin
                angle_hold_reg <= acc_reg[AW-1:8];
                acc_reg        <= '0;
                mcand_reg      <= AW'(filtered_reg);
                mplier_reg     <= rpc_reg;
                cnt_reg        <= esp_pkg::MUL_STEPS;
            end
            esp_pkg::ST_KEEP_RUN,
            esp_pkg::ST_NEW_RUN,
            esp_pkg::ST_ANGLE_RUN,
            esp_pkg::ST_SPEED_RUN: begin
                acc_reg    <= add_sum;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= cnt_reg - esp_pkg::CNT_W'(1);
            end
            default: ;
        endcase

        if (result_load) begin
            m_position_reg <= position_reg;
            m_angle_reg    <= angle_hold_reg;
            m_speed_reg    <= 40'(acc_reg[AW-1:20]);
        end
    end

endmodule

### sv/esp_checker.sv
// port-level checks for the encoder speed/position tracker, bound to the top level
// depends on assert_macros.svh and encoder_speed_position_tracker
`include "assert_macros.svh"

module esp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_position_count,
    input logic signed [47:0] m_angle_rad,
    input logic [39:0]        m_angular_velocity
);

    // an input transfer is always followed by s_ready low
    `CHK_NEXT(a_busy_after_transfer, aclk, aresetn, s_valid && s_ready, !s_ready)

    // a result never shows up the cycle right after its input transfer
    `CHK_NEXT(a_no_instant_result, aclk, aresetn, s_valid && s_ready && !m_valid, !m_valid)

    `CHK_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid)

    `CHK_NEXT(a_payload_held, aclk, aresetn, m_valid && !m_ready,
        $stable(m_position_count) && $stable(m_angle_rad) && $stable(m_angular_velocity))

endmodule

bind encoder_speed_position_tracker esp_checker u_esp_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_position_count   (m_position_count),
    .m_angle_rad        (m_angle_rad),
    .m_angular_velocity (m_angular_velocity)
);
